@@ rtl/bba_pkg.sv @@
// Shared types, constants and codes of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int unsigned NUM_BLOCKS  = 8192;
  localparam int unsigned BLOCK_SHIFT = 4;
  localparam logic [31:0] BASE_RESET  = 32'h0020_0000;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BLK_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int unsigned WIDX_W     = $clog2(NUM_WORDS);
  localparam int unsigned GRP_SIZE   = 8;
  localparam int unsigned GRP_SEL_W  = $clog2(GRP_SIZE);
  localparam int unsigned NUM_GROUPS = NUM_WORDS / GRP_SIZE;
  localparam int unsigned GRP_W      = WIDX_W - GRP_SEL_W;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_ADDR,
    S_FCHK,
    S_FMOD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic pick;
    logic mkaddr;
    logic fchk;
    logic fmod;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic all_full;
    logic bad_addr;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/bba_req_if.sv @@
// Request channel: allocate or free words with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] free_address;

  modport source (output valid, output req_type, output free_address, input ready);
  modport sink (input valid, input req_type, input free_address, output ready);
endinterface
`default_nettype wire

@@ rtl/bba_rsp_if.sv @@
// Response channel: block address and status words with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink (input valid, input block_address, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap block allocator: controller and datapath.
//
// Usage: requests arrive as words on req_i (valid/ready). req_type selects
// allocate (claim the lowest free 16-byte block of 8192) or free (release the
// block holding free_address). Each request gives exactly one response word
// on rsp_o: the block address and a status (ok, out of memory, bad address).
// The base address register resets to 0x200000; the block does not guard its
// writes; the user must write it via cfg_we_i / cfg_wdata_i only while idle.
// Steps: an allocate runs a summary scan with registered map read, then bit
// pick and map write, then address add, then result load; a free runs an
// offset check with map read, then map write, then result load. Out of memory
// and bad address go straight from the scan or check to result load. One
// request is worked on at a time, so the block takes a new request only once
// the last result is loaded into the output register. The map memory port and
// the single sequencer set this.
// A finished response sits in an output register; a new request is accepted
// while it waits, but its own result is held back until the register is free.
// Reset clears the usage map at once (per-word valid bits, no clearing pass).
`timescale 1ns / 1ps
`default_nettype none
module bitmap_block_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  bba_req_if.sink                         req_i,
  bba_rsp_if.source                       rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wdata_i
);

  bba_pkg::cmd_t    cmd;
  bba_pkg::sts_t    sts;
  bba_pkg::status_e out_status;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_type_i  (req_i.req_type),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .free_address_i (req_i.free_address),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .out_addr_o     (rsp_o.block_address),
    .out_status_o   (out_status)
  );

  assign rsp_o.status = out_status;

endmodule
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
// Sequencing state machine of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_type_i,
  output logic               in_ready_o,
  output bba_pkg::cmd_t      cmd_o,
  input  wire bba_pkg::sts_t sts_i
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_type_i == bba_pkg::REQ_FREE) ? bba_pkg::S_FCHK : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: state_d = sts_i.all_full ? bba_pkg::S_DONE : bba_pkg::S_PICK;
      bba_pkg::S_PICK: state_d = bba_pkg::S_ADDR;
      bba_pkg::S_ADDR: state_d = bba_pkg::S_DONE;
      bba_pkg::S_FCHK: state_d = sts_i.bad_addr ? bba_pkg::S_DONE : bba_pkg::S_FMOD;
      bba_pkg::S_FMOD: state_d = bba_pkg::S_DONE;
      bba_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bba_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bba_pkg::S_SCAN: cmd_o.scan     = 1'b1;
      bba_pkg::S_PICK: cmd_o.pick     = 1'b1;
      bba_pkg::S_ADDR: cmd_o.mkaddr   = 1'b1;
      bba_pkg::S_FCHK: cmd_o.fchk     = 1'b1;
      bba_pkg::S_FMOD: cmd_o.fmod     = 1'b1;
      bba_pkg::S_DONE: cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/bba_dp.sv @@
// Datapath: usage map memory, full-word summary, address arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none
module bba_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bba_pkg::cmd_t                cmd_i,
  output bba_pkg::sts_t                     sts_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic [bba_pkg::ADDR_W-1:0]   free_address_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bba_pkg::ADDR_W-1:0]        out_addr_o,
  output bba_pkg::status_e                  out_status_o
);

  logic [bba_pkg::ADDR_W-1:0] base_q;
  logic [bba_pkg::ADDR_W-1:0] faddr_q;

  // One bit per map word: set once the word is written, so unwritten words read as free.
  logic [bba_pkg::NUM_WORDS-1:0]  vld_q;
  // Summary level: a set bit means every block in that map word is used.
  logic [bba_pkg::NUM_WORDS-1:0]  full_q;
  logic [bba_pkg::WORD_W-1:0]     mem [bba_pkg::NUM_WORDS];
  logic [bba_pkg::WORD_W-1:0]     rdata_q;
  logic                           rvld_q;

  logic [bba_pkg::WIDX_W-1:0]     widx_q;
  logic [bba_pkg::BIT_W-1:0]      bit_q;

  logic [bba_pkg::ADDR_W-1:0]     res_addr_q;
  bba_pkg::status_e               res_st_q;
  logic                           out_vld_q;
  logic [bba_pkg::ADDR_W-1:0]     out_addr_q;
  bba_pkg::status_e               out_st_q;

  logic [bba_pkg::NUM_GROUPS-1:0] grp_full;
  logic                           all_full;
  logic [bba_pkg::GRP_W-1:0]      grp_idx;
  logic [bba_pkg::GRP_SIZE-1:0]   grp_row;
  logic [bba_pkg::GRP_SEL_W-1:0]  sub_idx;
  logic [bba_pkg::WIDX_W-1:0]     scan_widx;

  logic [bba_pkg::ADDR_W-1:0]     off;
  logic                           bad_addr;
  logic [bba_pkg::BLK_W-1:0]      off_blk;

  logic [bba_pkg::WORD_W-1:0]     rword;
  logic [bba_pkg::BIT_W-1:0]      pick_bit;
  logic [bba_pkg::WORD_W-1:0]     set_word;
  logic [bba_pkg::WORD_W-1:0]     clr_word;
  logic                           mem_we;
  logic [bba_pkg::WORD_W-1:0]     mem_wd;
  logic                           mem_re;
  logic [bba_pkg::WIDX_W-1:0]     mem_ra;
  logic [bba_pkg::BLK_W-1:0]      blk;

  // Two-level search: first group of words with room, then first word in it with room.
  always_comb begin
    for (int g = 0; g < bba_pkg::NUM_GROUPS; g++) begin
      grp_full[g] = &full_q[g*bba_pkg::GRP_SIZE +: bba_pkg::GRP_SIZE];
    end
    all_full = &grp_full;
    grp_idx  = '0;
    for (int g = bba_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (!grp_full[g]) grp_idx = bba_pkg::GRP_W'(g);
    end
    grp_row = full_q[{grp_idx, bba_pkg::GRP_SEL_W'(0)} +: bba_pkg::GRP_SIZE];
    sub_idx = '0;
    for (int s = bba_pkg::GRP_SIZE - 1; s >= 0; s--) begin
      if (!grp_row[s]) sub_idx = bba_pkg::GRP_SEL_W'(s);
    end
    scan_widx = {grp_idx, sub_idx};
  end

  assign off      = faddr_q - base_q;
  assign bad_addr = (off >> bba_pkg::BLOCK_SHIFT) >= bba_pkg::ADDR_W'(bba_pkg::NUM_BLOCKS);
  assign off_blk  = off[bba_pkg::BLOCK_SHIFT +: bba_pkg::BLK_W];

  assign rword = rvld_q ? rdata_q : '0;

  always_comb begin
    pick_bit = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!rword[b]) pick_bit = bba_pkg::BIT_W'(b);
    end
  end

  assign set_word = rword | (bba_pkg::WORD_W'(1) << pick_bit);
  assign clr_word = rword & ~(bba_pkg::WORD_W'(1) << bit_q);
  assign mem_we   = cmd_i.pick | cmd_i.fmod;
  assign mem_wd   = cmd_i.pick ? set_word : clr_word;
  assign mem_re   = cmd_i.scan | (cmd_i.fchk & ~bad_addr);
  assign mem_ra   = cmd_i.scan ? scan_widx : off_blk[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
  assign blk      = {widx_q, bit_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[widx_q] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      full_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_re) rvld_q <= vld_q[mem_ra];
      if (mem_we) begin
        vld_q[widx_q]  <= 1'b1;
        full_q[widx_q] <= cmd_i.pick ? &set_word : 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= bba_pkg::BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) faddr_q <= free_address_i;
    if (cmd_i.scan) widx_q <= scan_widx;
    if (cmd_i.fchk) begin
      widx_q <= off_blk[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
      bit_q  <= off_blk[bba_pkg::BIT_W-1:0];
    end
    if (cmd_i.pick) bit_q <= pick_bit;
    if (cmd_i.scan && all_full) begin
      res_addr_q <= '0;
      res_st_q   <= bba_pkg::ST_OOM;
    end
    if (cmd_i.mkaddr) begin
      res_addr_q <= base_q + (bba_pkg::ADDR_W'(blk) << bba_pkg::BLOCK_SHIFT);
      res_st_q   <= bba_pkg::ST_OK;
    end
    if (cmd_i.fchk && bad_addr) begin
      res_addr_q <= '0;
      res_st_q   <= bba_pkg::ST_BADADDR;
    end
    if (cmd_i.fmod) begin
      res_addr_q <= '0;
      res_st_q   <= bba_pkg::ST_OK;
    end
    if (cmd_i.load_out) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.all_full = all_full;
  assign sts_o.bad_addr = bad_addr;
  assign sts_o.out_free = ~out_vld_q | out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_st_q;

  // At most one datapath step is commanded in any cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.accept, cmd_i.scan, cmd_i.pick, cmd_i.mkaddr, cmd_i.fchk, cmd_i.fmod,
              cmd_i.load_out}))
    else $error("more than one datapath command at once");

  // The summary only ever steers the search to a word that has a free block.
  a_pick_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> !(&rword))
    else $error("allocation picked from a full map word");

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten while stalled");

  // After a pick, the summary bit of the written map word shows whether it became full.
  a_full_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |=> (full_q[$past(widx_q)] == (&$past(set_word))))
    else $error("full summary bit disagrees with written map word");

endmodule
`default_nettype wire
